>>> hdl/bpfm_pkg.sv
// ----------------------------------------------------------------------------
// bpfm_pkg: shared definitions for the break page frame mapper
// Sizes, command and status codes, configuration register indexes and the
// request/response structs between the top level and the frame bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfm_pkg;

  // Geometry.
  localparam int PAGES       = 128;
  localparam int FRAMES      = 256;
  localparam int PAGE_SHIFT  = 13;
  localparam int PAGE_W      = $clog2(PAGES);
  localparam int PAGE_CNT_W  = PAGE_W + 1;
  localparam int FRAME_W     = $clog2(FRAMES);
  localparam int FRAME_CNT_W = FRAME_W + 1;

  // Field widths of the stream payloads.
  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 21;
  localparam int PROT_W    = 3;
  localparam int STATUS_W  = 2;
  localparam int CHANGED_W = 8;
  localparam int ENT_FRAME_W = 8;
  localparam int IN_BITS   = CMD_W + ADDR_W + PAGE_W + PROT_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STATUS_W + ADDR_W + 1 + PROT_W + ENT_FRAME_W + CHANGED_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  // Page table entry as stored in memory: prot above frame.
  localparam int PTE_W = PROT_W + FRAME_W;

  // Frame bitmap rows.
  localparam int ROW_BITS  = 16;
  localparam int ROW_SEL_W = $clog2(ROW_BITS);
  localparam int ROWS      = FRAMES / ROW_BITS;
  localparam int ROW_W     = $clog2(ROWS);

  // Configuration port.
  localparam int CFG_IDX_W     = 1;
  localparam int FRAME_COUNT_W = 9;
  localparam int CFG_DATA_W    = FRAME_COUNT_W;
  localparam logic [CFG_IDX_W-1:0] CFG_VM_ENABLED  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'd1;
  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 9'd256;

  localparam logic [PROT_W-1:0] PROT_RW = 3'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_BREAK   = 2'd0,
    CMD_RESERVE = 2'd1,
    CMD_READ    = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_UNCHANGED = 2'd1,
    STS_NO_FRAME  = 2'd2,
    STS_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FM_ALLOC = 2'd0,
    FM_FREE  = 2'd1,
    FM_TSET  = 2'd2
  } fm_op_t;

  typedef struct packed {
    logic               valid;
    fm_op_t             op;
    logic [FRAME_W-1:0] frame;
  } fm_req_t;

  typedef struct packed {
    logic               done;
    logic               fail;
    logic [FRAME_W-1:0] frame;
  } fm_rsp_t;

  // Frames at or above this limit are never handed out.
  function automatic logic [FRAME_CNT_W-1:0] frame_limit(
    input logic [FRAME_COUNT_W-1:0] count
  );
    if (int'(count) > FRAMES) begin
      return FRAME_CNT_W'(FRAMES);
    end
    return FRAME_CNT_W'(count);
  endfunction

endpackage

`default_nettype wire

>>> hdl/break_page_frame_mapper_unit.sv
// ----------------------------------------------------------------------------
// break_page_frame_mapper_unit: break-driven page mapper with frame bitmap
// Page table in a synchronous memory with valid flags in flip-flops; frame
// allocation through the bpfm_frame_map bitmap unit.
//
//   Channel   Direction  Handshake              Payload
//   s_*       in         s_tvalid / s_tready    command, break_address, page_index, prot
//   m_*       out        m_tvalid / m_tready    status, break_now, entry fields, pages_changed
//   cfg_*     in         cfg_write              vm_enabled (0), frame_count (1)
//
// One request at a time. A break raise steps past already valid pages and
// allocates a frame for each new mapping, the bitmap scan passing full rows;
// a lowering steps past invalid pages and frees the frame of each valid one.
// Every frame allocation or free is a bitmap read-modify-write.
// Reset is synchronous and needs no clearing pass. A stalled result waits in
// the output register while the next request is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module break_page_frame_mapper_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // command[1:0], break_address[22:2], page_index[29:23], prot[32:30]
  input  wire logic [bpfm_pkg::IN_W-1:0]           s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // status[1:0], break_now[22:2], entry_valid[23], entry_prot[26:24],
  // entry_frame[34:27], pages_changed[42:35]
  output logic [bpfm_pkg::OUT_W-1:0]               m_tdata,
  input  wire logic                                cfg_write,
  input  wire logic [bpfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bpfm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b00000000001,
    S_DECODE     = 11'b00000000010,
    S_RAISE      = 11'b00000000100,
    S_ALLOC_WAIT = 11'b00000001000,
    S_LOWER      = 11'b00000010000,
    S_LOWER_RD   = 11'b00000100000,
    S_FREE_WAIT  = 11'b00001000000,
    S_RES_CHK    = 11'b00010000000,
    S_TSET_WAIT  = 11'b00100000000,
    S_READ_CHK   = 11'b01000000000,
    S_OUT        = 11'b10000000000
  } state_t;

  localparam int UP_W = bpfm_pkg::ADDR_W - bpfm_pkg::PAGE_SHIFT + 1;

  state_t                                   state;
  logic                                     vm_enabled;
  logic [bpfm_pkg::FRAME_COUNT_W-1:0]       frame_count;

  bpfm_pkg::cmd_t                           cmd_q;
  logic [bpfm_pkg::PAGE_W-1:0]              idx_q;
  logic [bpfm_pkg::PROT_W-1:0]              prot_q;
  logic [bpfm_pkg::PAGE_CNT_W-1:0]          tgt_page;
  logic [bpfm_pkg::PAGE_CNT_W-1:0]          brk_page;
  logic [bpfm_pkg::PAGE_CNT_W-1:0]          page;
  bpfm_pkg::status_t                        status_q;
  logic                                     ent_valid;
  logic [bpfm_pkg::PROT_W-1:0]              ent_prot;
  logic [bpfm_pkg::FRAME_W-1:0]             ent_frame;
  logic [bpfm_pkg::CHANGED_W-1:0]           changed;

  logic [bpfm_pkg::PAGES-1:0]               pt_valid;
  logic [bpfm_pkg::PTE_W-1:0]               pt_mem [bpfm_pkg::PAGES];
  logic [bpfm_pkg::PTE_W-1:0]               pt_rdata;
  logic [bpfm_pkg::PAGE_W-1:0]              pt_raddr;
  logic                                     pt_we;
  logic [bpfm_pkg::PAGE_W-1:0]              pt_waddr;
  logic [bpfm_pkg::PTE_W-1:0]               pt_wdata;
  logic [bpfm_pkg::PROT_W-1:0]              rd_prot;
  logic [bpfm_pkg::FRAME_W-1:0]             rd_frame;
  logic [bpfm_pkg::FRAME_W-1:0]             idx_frame;
  logic                                     cur_valid;
  logic                                     page_valid;

  logic [bpfm_pkg::ADDR_W-1:0]              in_addr;
  logic [UP_W-1:0]                          up_pages;
  logic [bpfm_pkg::PAGE_CNT_W-1:0]          in_tgt;
  logic                                     out_free;

  bpfm_pkg::fm_req_t                        fm_req;
  bpfm_pkg::fm_rsp_t                        fm_rsp;

  bpfm_frame_map u_frames (
    .clk         (clk),
    .rst         (rst),
    .frame_count (frame_count),
    .req         (fm_req),
    .rsp         (fm_rsp)
  );

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // Requested break clamped to the address space and rounded up to a page.
  assign in_addr  = s_tdata[bpfm_pkg::CMD_W +: bpfm_pkg::ADDR_W];
  assign up_pages = {1'b0, in_addr[bpfm_pkg::ADDR_W-1:bpfm_pkg::PAGE_SHIFT]}
                  + UP_W'(|in_addr[bpfm_pkg::PAGE_SHIFT-1:0]);
  assign in_tgt   = (in_addr > bpfm_pkg::ADDR_W'(bpfm_pkg::PAGES << bpfm_pkg::PAGE_SHIFT))
                  ? bpfm_pkg::PAGE_CNT_W'(bpfm_pkg::PAGES)
                  : up_pages[bpfm_pkg::PAGE_CNT_W-1:0];

  assign rd_prot    = pt_rdata[bpfm_pkg::PTE_W-1:bpfm_pkg::FRAME_W];
  assign rd_frame   = pt_rdata[bpfm_pkg::FRAME_W-1:0];
  assign idx_frame  = bpfm_pkg::FRAME_W'(idx_q);
  assign cur_valid  = pt_valid[idx_q];
  assign page_valid = pt_valid[page[bpfm_pkg::PAGE_W-1:0]];

  always_comb begin
    pt_raddr = (state == S_LOWER) ? page[bpfm_pkg::PAGE_W-1:0] : idx_q;
    pt_we    = 1'b0;
    pt_waddr = idx_q;
    pt_wdata = {prot_q, idx_frame};
    fm_req.valid = 1'b0;
    fm_req.op    = bpfm_pkg::FM_ALLOC;
    fm_req.frame = idx_frame;
    case (state)
      S_RAISE: begin
        fm_req.valid = (page != tgt_page) && !page_valid;
      end
      S_ALLOC_WAIT: begin
        pt_we    = fm_rsp.done && !fm_rsp.fail;
        pt_waddr = page[bpfm_pkg::PAGE_W-1:0];
        pt_wdata = {bpfm_pkg::PROT_RW, fm_rsp.frame};
      end
      S_LOWER_RD: begin
        fm_req.valid = 1'b1;
        fm_req.op    = bpfm_pkg::FM_FREE;
        fm_req.frame = rd_frame;
      end
      S_RES_CHK: begin
        // Identity entry already there: only the protection changes.
        pt_we        = cur_valid && (rd_frame == idx_frame);
        fm_req.valid = !cur_valid;
        fm_req.op    = bpfm_pkg::FM_TSET;
      end
      S_TSET_WAIT: begin
        pt_we = fm_rsp.done && !fm_rsp.fail;
      end
      default: begin
        pt_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm_enabled  <= 1'b0;
      frame_count <= bpfm_pkg::FRAME_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bpfm_pkg::CFG_VM_ENABLED:  vm_enabled  <= cfg_data[0];
        bpfm_pkg::CFG_FRAME_COUNT: frame_count <= cfg_data;
        default: begin
          vm_enabled <= vm_enabled;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      brk_page <= '0;
      pt_valid <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd_q     <= bpfm_pkg::cmd_t'(s_tdata[bpfm_pkg::CMD_W-1:0]);
            idx_q     <= s_tdata[bpfm_pkg::CMD_W + bpfm_pkg::ADDR_W +: bpfm_pkg::PAGE_W];
            prot_q    <= s_tdata[bpfm_pkg::IN_BITS-1 -: bpfm_pkg::PROT_W];
            tgt_page  <= in_tgt;
            status_q  <= bpfm_pkg::STS_OK;
            ent_valid <= 1'b0;
            ent_prot  <= '0;
            ent_frame <= '0;
            changed   <= '0;
            state     <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (cmd_q)
            bpfm_pkg::CMD_BREAK: begin
              if (!vm_enabled) begin
                brk_page <= tgt_page;
                state    <= S_OUT;
              end else if (tgt_page == brk_page) begin
                status_q <= bpfm_pkg::STS_UNCHANGED;
                state    <= S_OUT;
              end else if (tgt_page > brk_page) begin
                page  <= brk_page;
                state <= S_RAISE;
              end else begin
                page  <= tgt_page;
                state <= S_LOWER;
              end
            end
            bpfm_pkg::CMD_RESERVE: begin
              if ({1'b0, idx_frame} >= bpfm_pkg::frame_limit(frame_count)) begin
                status_q <= bpfm_pkg::STS_BAD_INDEX;
                state    <= S_OUT;
              end else begin
                state <= S_RES_CHK;
              end
            end
            bpfm_pkg::CMD_READ: begin
              state <= S_READ_CHK;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_RAISE: begin
          if (page == tgt_page) begin
            brk_page <= tgt_page;
            state    <= S_OUT;
          end else if (page_valid) begin
            page <= page + bpfm_pkg::PAGE_CNT_W'(1);
          end else begin
            state <= S_ALLOC_WAIT;
          end
        end
        S_ALLOC_WAIT: begin
          if (fm_rsp.done) begin
            if (fm_rsp.fail) begin
              // The break stops at the page that found no frame.
              status_q <= bpfm_pkg::STS_NO_FRAME;
              brk_page <= page;
              state    <= S_OUT;
            end else begin
              pt_valid[page[bpfm_pkg::PAGE_W-1:0]] <= 1'b1;
              changed <= changed + bpfm_pkg::CHANGED_W'(1);
              page    <= page + bpfm_pkg::PAGE_CNT_W'(1);
              state   <= S_RAISE;
            end
          end
        end
        S_LOWER: begin
          if (page == brk_page) begin
            brk_page <= tgt_page;
            state    <= S_OUT;
          end else if (page_valid) begin
            state <= S_LOWER_RD;
          end else begin
            page <= page + bpfm_pkg::PAGE_CNT_W'(1);
          end
        end
        S_LOWER_RD: begin
          pt_valid[page[bpfm_pkg::PAGE_W-1:0]] <= 1'b0;
          changed <= changed + bpfm_pkg::CHANGED_W'(1);
          state   <= S_FREE_WAIT;
        end
        S_FREE_WAIT: begin
          if (fm_rsp.done) begin
            page  <= page + bpfm_pkg::PAGE_CNT_W'(1);
            state <= S_LOWER;
          end
        end
        S_RES_CHK: begin
          if (cur_valid) begin
            ent_valid <= 1'b1;
            ent_frame <= rd_frame;
            if (rd_frame == idx_frame) begin
              ent_prot <= prot_q;
            end else begin
              ent_prot <= rd_prot;
              status_q <= bpfm_pkg::STS_NO_FRAME;
            end
            state <= S_OUT;
          end else begin
            state <= S_TSET_WAIT;
          end
        end
        S_TSET_WAIT: begin
          if (fm_rsp.done) begin
            if (fm_rsp.fail) begin
              status_q <= bpfm_pkg::STS_NO_FRAME;
            end else begin
              pt_valid[idx_q] <= 1'b1;
              ent_valid <= 1'b1;
              ent_prot  <= prot_q;
              ent_frame <= idx_frame;
            end
            state <= S_OUT;
          end
        end
        S_READ_CHK: begin
          if (cur_valid) begin
            ent_valid <= 1'b1;
            ent_prot  <= rd_prot;
            ent_frame <= rd_frame;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      m_tdata <= bpfm_pkg::OUT_W'({
        changed,
        bpfm_pkg::ENT_FRAME_W'(ent_frame),
        ent_prot,
        ent_valid,
        bpfm_pkg::ADDR_W'({brk_page, {bpfm_pkg::PAGE_SHIFT{1'b0}}}),
        status_q
      });
    end
  end

  a_break_range: assert property (@(posedge clk) disable iff (rst)
    brk_page <= bpfm_pkg::PAGE_CNT_W'(bpfm_pkg::PAGES))
    else $error("break beyond address space");

  a_req_enters_wait: assert property (@(posedge clk) disable iff (rst)
    fm_req.valid |=> (state == S_ALLOC_WAIT || state == S_FREE_WAIT ||
                      state == S_TSET_WAIT))
    else $error("frame request without wait state");

  a_alloc_free_page: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC_WAIT && fm_rsp.done) |-> !page_valid)
    else $error("frame allocated for a page already mapped");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RAISE || state == S_LOWER) |-> page <= bpfm_pkg::PAGE_CNT_W'(bpfm_pkg::PAGES))
    else $error("page walk beyond page table");

endmodule

`default_nettype wire

>>> hdl/bpfm_frame_map.sv
// ----------------------------------------------------------------------------
// bpfm_frame_map: used-frame bitmap
// Rows of frame-used bits in a synchronous memory with per-row valid flags.
// Serves allocate-lowest, free and test-and-set requests by read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfm_frame_map (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [bpfm_pkg::FRAME_COUNT_W-1:0]     frame_count,
  input  wire bpfm_pkg::fm_req_t                      req,
  output bpfm_pkg::fm_rsp_t                           rsp
);

  typedef enum logic [1:0] {
    F_IDLE  = 2'b01,
    F_CHECK = 2'b10
  } fstate_t;

  fstate_t                               state;
  bpfm_pkg::fm_op_t                      op_q;
  logic [bpfm_pkg::ROW_W-1:0]            row_q;
  logic [bpfm_pkg::ROW_SEL_W-1:0]        bit_q;
  // Every row below hint is fully used.
  logic [bpfm_pkg::ROW_W:0]              hint;

  logic [bpfm_pkg::ROW_BITS-1:0]         mem [bpfm_pkg::ROWS];
  logic [bpfm_pkg::ROWS-1:0]             row_valid;
  logic [bpfm_pkg::ROW_BITS-1:0]         rdata;
  logic                                  rvld;

  logic [bpfm_pkg::ROW_W-1:0]            rd_row;
  logic [bpfm_pkg::ROW_BITS-1:0]         row;
  logic [bpfm_pkg::ROW_BITS-1:0]         bit_mask;
  logic [bpfm_pkg::ROW_SEL_W-1:0]        free_bit;
  logic                                  full;
  logic                                  last_row;
  logic [bpfm_pkg::FRAME_W-1:0]          alloc_frame;
  logic [bpfm_pkg::FRAME_CNT_W-1:0]      limit;
  logic                                  alloc_ok;
  logic                                  we;
  logic [bpfm_pkg::ROW_BITS-1:0]         wdata;
  logic                                  done_next;

  function automatic logic [bpfm_pkg::ROW_SEL_W-1:0] first_zero(
    input logic [bpfm_pkg::ROW_BITS-1:0] v
  );
    logic [bpfm_pkg::ROW_SEL_W-1:0] pos;
    pos = '0;
    for (int i = bpfm_pkg::ROW_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        pos = bpfm_pkg::ROW_SEL_W'(i);
      end
    end
    return pos;
  endfunction

  always_comb begin
    if (state == F_IDLE) begin
      rd_row = (req.op == bpfm_pkg::FM_ALLOC) ? hint[bpfm_pkg::ROW_W-1:0]
                                              : req.frame[bpfm_pkg::FRAME_W-1:bpfm_pkg::ROW_SEL_W];
    end else begin
      rd_row = row_q + bpfm_pkg::ROW_W'(1);
    end
  end

  assign row         = rvld ? rdata : '0;
  assign bit_mask    = bpfm_pkg::ROW_BITS'(1) << bit_q;
  assign free_bit    = first_zero(row);
  assign full        = &row;
  assign last_row    = (row_q == bpfm_pkg::ROW_W'(bpfm_pkg::ROWS - 1));
  assign alloc_frame = {row_q, free_bit};
  assign limit       = bpfm_pkg::frame_limit(frame_count);
  assign alloc_ok    = ({1'b0, alloc_frame} < limit);

  always_comb begin
    we    = 1'b0;
    wdata = row | bit_mask;
    if (state == F_CHECK) begin
      case (op_q)
        bpfm_pkg::FM_ALLOC: begin
          we    = !full && alloc_ok;
          wdata = row | (bpfm_pkg::ROW_BITS'(1) << free_bit);
        end
        bpfm_pkg::FM_FREE: begin
          we    = 1'b1;
          wdata = row & ~bit_mask;
        end
        bpfm_pkg::FM_TSET: begin
          we    = !(|(row & bit_mask));
          wdata = row | bit_mask;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  // A response is due when an allocation finds the bitmap exhausted at once
  // or when a check ends; a full row in mid-scan moves on to the next row.
  always_comb begin
    case (state)
      F_IDLE: begin
        done_next = req.valid && req.op == bpfm_pkg::FM_ALLOC &&
                    hint == (bpfm_pkg::ROW_W + 1)'(bpfm_pkg::ROWS);
      end
      F_CHECK: begin
        done_next = (op_q == bpfm_pkg::FM_FREE) || (op_q == bpfm_pkg::FM_TSET) ||
                    (op_q == bpfm_pkg::FM_ALLOC && !(full && !last_row));
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Bitmap memory with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[row_q] <= wdata;
    end
    rdata <= mem[rd_row];
    rvld  <= row_valid[rd_row];
  end

  // A row never written reads as all free.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (we) begin
      row_valid[row_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      hint      <= '0;
      rsp.done  <= 1'b0;
      rsp.fail  <= 1'b0;
      rsp.frame <= '0;
      op_q      <= bpfm_pkg::FM_ALLOC;
      row_q     <= '0;
      bit_q     <= '0;
    end else begin
      rsp.done <= done_next;
      case (state)
        F_IDLE: begin
          if (req.valid) begin
            op_q  <= req.op;
            bit_q <= req.frame[bpfm_pkg::ROW_SEL_W-1:0];
            row_q <= rd_row;
            if (req.op == bpfm_pkg::FM_ALLOC &&
                hint == (bpfm_pkg::ROW_W + 1)'(bpfm_pkg::ROWS)) begin
              rsp.fail <= 1'b1;
            end else begin
              state <= F_CHECK;
            end
          end
        end
        F_CHECK: begin
          case (op_q)
            bpfm_pkg::FM_ALLOC: begin
              if (full) begin
                if (last_row) begin
                  hint     <= (bpfm_pkg::ROW_W + 1)'(bpfm_pkg::ROWS);
                  rsp.fail <= 1'b1;
                  state    <= F_IDLE;
                end else begin
                  // Row exhausted; the next row is being read this cycle.
                  row_q <= row_q + bpfm_pkg::ROW_W'(1);
                  hint  <= {1'b0, row_q} + (bpfm_pkg::ROW_W + 1)'(1);
                end
              end else begin
                rsp.fail  <= !alloc_ok;
                rsp.frame <= alloc_frame;
                state     <= F_IDLE;
              end
            end
            bpfm_pkg::FM_FREE: begin
              if ({1'b0, row_q} < hint) begin
                hint <= {1'b0, row_q};
              end
              rsp.fail <= 1'b0;
              state    <= F_IDLE;
            end
            bpfm_pkg::FM_TSET: begin
              rsp.fail <= |(row & bit_mask);
              state    <= F_IDLE;
            end
            default: begin
              state <= F_IDLE;
            end
          endcase
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    hint <= (bpfm_pkg::ROW_W + 1)'(bpfm_pkg::ROWS))
    else $error("frame hint beyond last row");

  a_req_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.valid |-> state == F_IDLE)
    else $error("frame request while busy");

  a_alloc_in_limit: assert property (@(posedge clk) disable iff (rst)
    (rsp.done && !rsp.fail && op_q == bpfm_pkg::FM_ALLOC) |-> ({1'b0, rsp.frame} < limit))
    else $error("allocated frame at or above limit");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    rsp.done |=> !rsp.done)
    else $error("back-to-back frame responses");

endmodule

`default_nettype wire
